### hdl/tar_pkg.sv
// Shared widths, constants and sideband types for the triangle aspect ratio block.
package tar_pkg;

  localparam int COORD_BITS      = 16;
  localparam int RATIO_FRAC_BITS = 8;
  localparam int RATIO_BITS      = 24;

  localparam int DIFF_W = COORD_BITS + 1;           // coordinate difference
  localparam int PRD_W  = 2 * DIFF_W;               // signed product
  localparam int SQ_W   = 2 * DIFF_W - 2;           // square of a difference
  localparam int LEN_W  = SQ_W + 2;                 // sum of three squares
  localparam int CR_W   = PRD_W;                    // cross product component
  localparam int ABS_W  = CR_W - 1;                 // its magnitude
  localparam int LO_W   = (ABS_W + 1) / 2;
  localparam int HI_W   = ABS_W - LO_W;
  localparam int C2_W   = 2 * ABS_W + 2;            // squared cross magnitude
  localparam int ROOT_W = C2_W / 2;
  localparam int NUM_W  = LEN_W + RATIO_FRAC_BITS;  // dividend

  localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;

  typedef enum logic [1:0] {
    EDGE_AB = 2'd0,
    EDGE_BC = 2'd1,
    EDGE_CA = 2'd2
  } tar_edge_e;

  // Travels with the item through the square root stages.
  typedef struct packed {
    logic             valid;
    logic             degen;
    tar_edge_e        which;
    logic [LEN_W-1:0] best;
  } tar_side_t;

  // Travels with the item through the divider stages.
  typedef struct packed {
    logic      valid;
    logic      degen;
    logic      sat;
    tar_edge_e which;
  } tar_tag_t;

endpackage

### hdl/tar_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
module tar_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [tar_pkg::C2_W-1:0]   c2_i,
  input  tar_pkg::tar_side_t         side_i,
  output logic [tar_pkg::ROOT_W-1:0] root_o,
  output tar_pkg::tar_side_t         side_o
);

  localparam int NS    = tar_pkg::ROOT_W;
  localparam int REM_W = tar_pkg::ROOT_W + 1;
  localparam int TMP_W = tar_pkg::ROOT_W + 3;

  logic [tar_pkg::C2_W-1:0]   n_s    [NS+1];
  logic [REM_W-1:0]           rem_s  [NS+1];
  logic [tar_pkg::ROOT_W-1:0] root_s [NS+1];
  tar_pkg::tar_side_t         side_s [NS+1];

  assign n_s[0]    = c2_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [TMP_W-1:0] tmp;
    logic [TMP_W-1:0] trial;
    logic             ge;

    always_comb begin
      tmp   = {rem_s[k], n_s[k][tar_pkg::C2_W-1 -: 2]};
      trial = {1'b0, root_s[k], 2'b01};
      ge    = (tmp >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_s[k+1] <= '0;
      end else if (en_i) begin
        side_s[k+1] <= side_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_s[k+1]    <= n_s[k] << 2;
        rem_s[k+1]  <= ge ? REM_W'(tmp - trial) : REM_W'(tmp);
        root_s[k+1] <= {root_s[k][tar_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign root_o = root_s[NS];
  assign side_o = side_s[NS];

endmodule

### hdl/tar_div.sv
// Pipelined saturating restoring divider, one quotient bit per register stage.
module tar_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [tar_pkg::ROOT_W-1:0]     root_i,
  input  tar_pkg::tar_side_t             side_i,
  output logic [tar_pkg::RATIO_BITS-1:0] ratio_o,
  output tar_pkg::tar_tag_t              tag_o
);

  localparam int NS     = tar_pkg::RATIO_BITS;
  localparam int DREM_W = tar_pkg::ROOT_W + 1;
  localparam int HI_N   = tar_pkg::NUM_W - tar_pkg::RATIO_BITS;

  logic [tar_pkg::NUM_W-1:0] num;
  logic [HI_N-1:0]           num_hi;

  logic [DREM_W-1:0]              rem_s  [NS+1];
  logic [tar_pkg::RATIO_BITS-1:0] lo_s   [NS+1];
  logic [tar_pkg::RATIO_BITS-1:0] q_s    [NS+1];
  logic [tar_pkg::ROOT_W-1:0]     root_s [NS+1];
  tar_pkg::tar_tag_t              tag_s  [NS+1];

  assign num    = {side_i.best, {tar_pkg::RATIO_FRAC_BITS{1'b0}}};
  assign num_hi = num[tar_pkg::NUM_W-1:tar_pkg::RATIO_BITS];

  // Quotient would need 2^24 or more: saturate. A zero root lands here too.
  assign tag_s[0].valid = side_i.valid;
  assign tag_s[0].degen = side_i.degen;
  assign tag_s[0].which = side_i.which;
  assign tag_s[0].sat   = (DREM_W'(num_hi) >= DREM_W'(root_i));
  assign rem_s[0]       = DREM_W'(num_hi);
  assign lo_s[0]        = num[tar_pkg::RATIO_BITS-1:0];
  assign q_s[0]         = '0;
  assign root_s[0]      = root_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DREM_W-1:0] tmp;
    logic              ge;

    always_comb begin
      tmp = {rem_s[k][DREM_W-2:0], lo_s[k][tar_pkg::RATIO_BITS-1]};
      ge  = (tmp >= DREM_W'(root_s[k]));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_s[k+1] <= '0;
      end else if (en_i) begin
        tag_s[k+1] <= tag_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1]  <= ge ? (tmp - DREM_W'(root_s[k])) : tmp;
        lo_s[k+1]   <= lo_s[k] << 1;
        q_s[k+1]    <= {q_s[k][tar_pkg::RATIO_BITS-2:0], ge};
        root_s[k+1] <= root_s[k];
      end
    end
  end

  assign tag_o   = tag_s[NS];
  assign ratio_o = tag_s[NS].sat ? tar_pkg::RATIO_MAX : q_s[NS];

endmodule

### hdl/triangle_aspect_ratio.sv
// Throughput: one triangle per cycle while the output is not stalled; 7 front
// stages, 34 square root stages (one root bit each) and 24 divider stages
// (one quotient bit each).
// A stall on a valid output freezes the whole pipeline; stall_o follows it.
// Reset (rst_ni low, async) clears valid bits and isqrt/div tags, not data.
module triangle_aspect_ratio (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [tar_pkg::COORD_BITS-1:0] a_x_i,
  input  logic [tar_pkg::COORD_BITS-1:0] a_y_i,
  input  logic [tar_pkg::COORD_BITS-1:0] a_z_i,
  input  logic [tar_pkg::COORD_BITS-1:0] b_x_i,
  input  logic [tar_pkg::COORD_BITS-1:0] b_y_i,
  input  logic [tar_pkg::COORD_BITS-1:0] b_z_i,
  input  logic [tar_pkg::COORD_BITS-1:0] c_x_i,
  input  logic [tar_pkg::COORD_BITS-1:0] c_y_i,
  input  logic [tar_pkg::COORD_BITS-1:0] c_z_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [tar_pkg::RATIO_BITS-1:0] ratio_o,
  output logic                           degenerate_o,
  output logic [1:0]                     longest_edge_o
);

  localparam int DW = tar_pkg::DIFF_W;

  logic en;
  logic [7:1] v_q;

  logic signed [tar_pkg::COORD_BITS-1:0] p [3][3];

  logic signed [DW-1:0]              e_q   [3][3];
  logic signed [DW-1:0]              w_q   [3];
  logic        [tar_pkg::SQ_W-1:0]   sq_q  [3][3];
  logic signed [tar_pkg::PRD_W-1:0]  pr_q  [6];
  logic        [tar_pkg::LEN_W-1:0]  len_q [3];
  logic signed [tar_pkg::CR_W-1:0]   cr_q  [3];
  logic        [tar_pkg::ABS_W-1:0]  cm_q  [3];
  logic        [2*tar_pkg::HI_W-1:0] hh_q  [3];
  logic        [tar_pkg::ABS_W-1:0]  hl_q  [3];
  logic        [2*tar_pkg::LO_W-1:0] ll_q  [3];
  logic        [tar_pkg::C2_W-1:0]   csq_q [3];
  logic        [tar_pkg::C2_W-1:0]   c2_q;

  logic                      degen4_q, degen5_q, degen6_q, degen7_q;
  tar_pkg::tar_edge_e        which4_q, which5_q, which6_q, which7_q;
  logic [tar_pkg::LEN_W-1:0] best4_q, best5_q, best6_q, best7_q;

  logic signed [tar_pkg::PRD_W-1:0] sq_full [3][3];
  logic signed [tar_pkg::PRD_W-1:0] pr_full [6];
  logic        [tar_pkg::LEN_W-1:0] best_c;
  tar_pkg::tar_edge_e               which_c;

  tar_pkg::tar_side_t side_in, side_sq;
  logic [tar_pkg::ROOT_W-1:0] root;
  tar_pkg::tar_tag_t tag;

  assign en      = !(valid_o && stall_i);
  assign stall_o = valid_o && stall_i;

  assign p[0][0] = a_x_i;
  assign p[0][1] = a_y_i;
  assign p[0][2] = a_z_i;
  assign p[1][0] = b_x_i;
  assign p[1][1] = b_y_i;
  assign p[1][2] = b_z_i;
  assign p[2][0] = c_x_i;
  assign p[2][1] = c_y_i;
  assign p[2][2] = c_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:1], valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        sq_full[i][k] = tar_pkg::PRD_W'(e_q[i][k]) * tar_pkg::PRD_W'(e_q[i][k]);
      end
    end
    // u = b - a is edge a-b, w = c - a
    pr_full[0] = tar_pkg::PRD_W'(e_q[0][1]) * tar_pkg::PRD_W'(w_q[2]);
    pr_full[1] = tar_pkg::PRD_W'(e_q[0][2]) * tar_pkg::PRD_W'(w_q[1]);
    pr_full[2] = tar_pkg::PRD_W'(e_q[0][2]) * tar_pkg::PRD_W'(w_q[0]);
    pr_full[3] = tar_pkg::PRD_W'(e_q[0][0]) * tar_pkg::PRD_W'(w_q[2]);
    pr_full[4] = tar_pkg::PRD_W'(e_q[0][0]) * tar_pkg::PRD_W'(w_q[1]);
    pr_full[5] = tar_pkg::PRD_W'(e_q[0][1]) * tar_pkg::PRD_W'(w_q[0]);
  end

  // First strictly greater wins.
  always_comb begin
    best_c  = len_q[0];
    which_c = tar_pkg::EDGE_AB;
    if (len_q[1] > best_c) begin
      best_c  = len_q[1];
      which_c = tar_pkg::EDGE_BC;
    end
    if (len_q[2] > best_c) begin
      best_c  = len_q[2];
      which_c = tar_pkg::EDGE_CA;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: differences
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          e_q[i][k] <= DW'(p[(i == 2) ? 0 : i + 1][k]) - DW'(p[i][k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        w_q[k] <= DW'(p[2][k]) - DW'(p[0][k]);
      end
      // stage 2: products
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          sq_q[i][k] <= sq_full[i][k][tar_pkg::SQ_W-1:0];
        end
      end
      for (int j = 0; j < 6; j++) begin
        pr_q[j] <= pr_full[j];
      end
      // stage 3: squared lengths and cross product
      for (int i = 0; i < 3; i++) begin
        len_q[i] <= tar_pkg::LEN_W'(sq_q[i][0]) + tar_pkg::LEN_W'(sq_q[i][1])
                  + tar_pkg::LEN_W'(sq_q[i][2]);
      end
      cr_q[0] <= pr_q[0] - pr_q[1];
      cr_q[1] <= pr_q[2] - pr_q[3];
      cr_q[2] <= pr_q[4] - pr_q[5];
      // stage 4: magnitudes, longest edge, zero area
      for (int k = 0; k < 3; k++) begin
        cm_q[k] <= cr_q[k][tar_pkg::CR_W-1] ? tar_pkg::ABS_W'(-cr_q[k])
                                            : tar_pkg::ABS_W'(cr_q[k]);
      end
      degen4_q <= (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
      which4_q <= which_c;
      best4_q  <= best_c;
      // stage 5: partial products of the magnitude squares
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= (2*tar_pkg::HI_W)'(cm_q[k][tar_pkg::ABS_W-1:tar_pkg::LO_W])
                 * (2*tar_pkg::HI_W)'(cm_q[k][tar_pkg::ABS_W-1:tar_pkg::LO_W]);
        hl_q[k] <= tar_pkg::ABS_W'(cm_q[k][tar_pkg::ABS_W-1:tar_pkg::LO_W])
                 * tar_pkg::ABS_W'(cm_q[k][tar_pkg::LO_W-1:0]);
        ll_q[k] <= (2*tar_pkg::LO_W)'(cm_q[k][tar_pkg::LO_W-1:0])
                 * (2*tar_pkg::LO_W)'(cm_q[k][tar_pkg::LO_W-1:0]);
      end
      degen5_q <= degen4_q;
      which5_q <= which4_q;
      best5_q  <= best4_q;
      // stage 6: assemble each square
      for (int k = 0; k < 3; k++) begin
        csq_q[k] <= (tar_pkg::C2_W'(hh_q[k]) << (2*tar_pkg::LO_W))
                  + (tar_pkg::C2_W'(hl_q[k]) << (tar_pkg::LO_W + 1))
                  + tar_pkg::C2_W'(ll_q[k]);
      end
      degen6_q <= degen5_q;
      which6_q <= which5_q;
      best6_q  <= best5_q;
      // stage 7: squared cross magnitude
      c2_q     <= csq_q[0] + csq_q[1] + csq_q[2];
      degen7_q <= degen6_q;
      which7_q <= which6_q;
      best7_q  <= best6_q;
    end
  end

  assign side_in.valid = v_q[7];
  assign side_in.degen = degen7_q;
  assign side_in.which = which7_q;
  assign side_in.best  = best7_q;

  tar_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .c2_i   (c2_q),
    .side_i (side_in),
    .root_o (root),
    .side_o (side_sq)
  );

  tar_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .root_i  (root),
    .side_i  (side_sq),
    .ratio_o (ratio_o),
    .tag_o   (tag)
  );

  assign valid_o        = tag.valid;
  assign degenerate_o   = tag.degen;
  assign longest_edge_o = tag.which;

`ifndef SYNTH
  a_degen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> ratio_o == tar_pkg::RATIO_MAX)
    else $error("degenerate result without saturated ratio");

  a_edge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> longest_edge_o != 2'd3)
    else $error("longest edge code out of range");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(v_q) && $stable(c2_q))
    else $error("front pipeline moved during output stall");

  a_zero_root_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_sq.valid && root == '0 |-> side_sq.degen)
    else $error("zero root on a nondegenerate triangle");
`endif

endmodule
